/* rtl/fbc_pkg.sv */
package fbc_pkg;

    // Width of one box coordinate, signed Q8.8 at the default of 16 bits.
    localparam int COORD_WIDTH = 16;

    // Plane packing: three Q1.14 normal components, then a Q8.8 offset.
    localparam int NORM_W      = 16;
    localparam int PLANE_W     = 4 * NORM_W;
    localparam int PLANE_COUNT = 6;
    localparam int CFG_IDX_W   = 3;

    // Shift that brings a Q8.8 offset to the fraction bits of a Q1.14 by Q8.8 product.
    localparam int OFFSET_SHIFT = 14;

    // Product widths: n * c is signed by signed, |n| * e carries a zero sign bit on |n|.
    localparam int PC_W = NORM_W + COORD_WIDTH;
    localparam int PE_W = NORM_W + 1 + COORD_WIDTH;

    // Accumulator wide enough for three products plus the scaled offset.
    localparam int ACC_W = COORD_WIDTH + 19;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_RIGHT  = 3'd0,
        PLANE_LEFT   = 3'd1,
        PLANE_TOP    = 3'd2,
        PLANE_BOTTOM = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } t_plane_idx;

    // Plane held by each cell of the chain, in chain order.
    localparam t_plane_idx CELL_PLANE [PLANE_COUNT] = '{
        PLANE_RIGHT, PLANE_LEFT, PLANE_TOP, PLANE_BOTTOM, PLANE_NEAR, PLANE_FAR
    };

    // Box as center and half extents.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
        logic signed [COORD_WIDTH-1:0] e_x;
        logic signed [COORD_WIDTH-1:0] e_y;
        logic signed [COORD_WIDTH-1:0] e_z;
    } t_box;

    // One beat as it moves from cell to cell.
    typedef struct packed {
        logic valid;
        logic vis;
        t_box box;
    } t_beat;

    // Plane write as seen by one cell.
    typedef struct packed {
        logic               we;
        logic [PLANE_W-1:0] data;
    } t_plane_wr;

endpackage

/* rtl/fbc_prep.sv */
module fbc_prep import fbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    output t_beat                         o_beat
);

    logic signed [COORD_WIDTH:0] sum_x, sum_y, sum_z;
    logic signed [COORD_WIDTH:0] dif_x, dif_y, dif_z;
    t_beat r_beat;
    t_beat n_beat;

    // Sums and differences one bit wider, so nothing overflows before halving.
    assign sum_x = {i_max_x[COORD_WIDTH-1], i_max_x} + {i_min_x[COORD_WIDTH-1], i_min_x};
    assign sum_y = {i_max_y[COORD_WIDTH-1], i_max_y} + {i_min_y[COORD_WIDTH-1], i_min_y};
    assign sum_z = {i_max_z[COORD_WIDTH-1], i_max_z} + {i_min_z[COORD_WIDTH-1], i_min_z};
    assign dif_x = {i_max_x[COORD_WIDTH-1], i_max_x} - {i_min_x[COORD_WIDTH-1], i_min_x};
    assign dif_y = {i_max_y[COORD_WIDTH-1], i_max_y} - {i_min_y[COORD_WIDTH-1], i_min_y};
    assign dif_z = {i_max_z[COORD_WIDTH-1], i_max_z} - {i_min_z[COORD_WIDTH-1], i_min_z};

    // Dropping the low bit is an arithmetic halving that rounds toward minus infinity.
    always_comb begin
        n_beat.valid   = i_valid;
        n_beat.vis     = 1'b1;
        n_beat.box.c_x = sum_x[COORD_WIDTH:1];
        n_beat.box.c_y = sum_y[COORD_WIDTH:1];
        n_beat.box.c_z = sum_z[COORD_WIDTH:1];
        n_beat.box.e_x = dif_x[COORD_WIDTH:1];
        n_beat.box.e_y = dif_y[COORD_WIDTH:1];
        n_beat.box.e_z = dif_z[COORD_WIDTH:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.vis <= n_beat.vis;
        r_beat.box <= n_beat.box;
    end

    assign o_beat = r_beat;

endmodule

/* rtl/fbc_cell.sv */
module fbc_cell import fbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plane_wr i_wr,
    input  t_beat     i_beat,
    output t_beat     o_beat
);

    logic [PLANE_W-1:0] r_plane;

    logic signed [NORM_W-1:0] nrm [3];
    logic [NORM_W-1:0]        mag [3];
    logic signed [NORM_W-1:0] ofs;
    logic signed [COORD_WIDTH-1:0] ctr [3];
    logic signed [COORD_WIDTH-1:0] ext [3];

    // Stage A: products.
    t_beat r_a_beat;
    logic signed [PC_W-1:0] r_pc [3];
    logic signed [PE_W-1:0] r_pe [3];

    // Stage B: distance and radius.
    t_beat r_b_beat;
    logic signed [ACC_W-1:0] r_dist;
    logic signed [ACC_W-1:0] r_rad;
    logic signed [ACC_W-1:0] n_dist;
    logic signed [ACC_W-1:0] n_rad;

    // Stage C: the running visibility flag leaves the cell.
    t_beat r_c_beat;

    // Per-cell plane register; user changes it only while the chain is empty, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_wr.we) begin
            r_plane <= i_wr.data;
        end
    end

    // Unpack the plane; the magnitude of a Q1.14 value fits in 16 bits unsigned.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k] = r_plane[k*NORM_W +: NORM_W];
            mag[k] = nrm[k][NORM_W-1] ? NORM_W'(-nrm[k]) : NORM_W'(nrm[k]);
        end
        ofs    = r_plane[3*NORM_W +: NORM_W];
        ctr[0] = i_beat.box.c_x;
        ctr[1] = i_beat.box.c_y;
        ctr[2] = i_beat.box.c_z;
        ext[0] = i_beat.box.e_x;
        ext[1] = i_beat.box.e_y;
        ext[2] = i_beat.box.e_z;
    end

    // Stage A registers one product per axis for the distance and one for the radius.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_beat.valid <= 1'b0;
        end else begin
            r_a_beat.valid <= i_beat.valid;
        end
        r_a_beat.vis <= i_beat.vis;
        r_a_beat.box <= i_beat.box;
        for (int k = 0; k < 3; k++) begin
            r_pc[k] <= nrm[k] * ctr[k];
            r_pe[k] <= $signed({1'b0, mag[k]}) * ext[k];
        end
    end

    // Stage B sums at full width; the offset is scaled to the product's fraction bits.
    always_comb begin
        n_dist = (ACC_W'(ofs) <<< OFFSET_SHIFT) + ACC_W'(r_pc[0]) + ACC_W'(r_pc[1])
               + ACC_W'(r_pc[2]);
        n_rad  = ACC_W'(r_pe[0]) + ACC_W'(r_pe[1]) + ACC_W'(r_pe[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_beat.valid <= 1'b0;
        end else begin
            r_b_beat.valid <= r_a_beat.valid;
        end
        r_b_beat.vis <= r_a_beat.vis;
        r_b_beat.box <= r_a_beat.box;
        r_dist       <= n_dist;
        r_rad        <= n_rad;
    end

    // Stage C: a distance equal to the radius counts as outside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_beat.valid <= 1'b0;
        end else begin
            r_c_beat.valid <= r_b_beat.valid;
        end
        r_c_beat.vis <= r_b_beat.vis & (r_dist < r_rad);
        r_c_beat.box <= r_b_beat.box;
    end

    assign o_beat = r_c_beat;

endmodule

/* rtl/frustum_box_cull_test.sv */
// Channel   Handshake           Payload
// --------  ------------------  ------------------------------------------------
// box in    i_start / o_busy    i_box_min_x/y/z, i_box_max_x/y/z (signed Q8.8)
// result    o_done (strobe)     o_visible
// config    i_cfg_we            i_cfg_index (0..5, others ignored), i_cfg_data
//
// One box is accepted in every cycle; o_busy is always low.
// A box passes a register that forms center and extents, then the six plane cells,
// each with a product, a sum and a compare stage.
// Reset clears the plane registers and the beat valid bits of the chain.
// The receiver cannot stall, so results leave the chain as they arrive.
module frustum_box_cull_test import fbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_z,
    output logic                          o_done,
    output logic                          o_visible,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [PLANE_W-1:0]            i_cfg_data
);

    t_beat     chain [PLANE_COUNT+1];
    t_plane_wr wr    [PLANE_COUNT];

    // The chain takes a new beat in every cycle.
    assign o_busy = 1'b0;

    fbc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start & ~o_busy),
        .i_min_x (i_box_min_x),
        .i_min_y (i_box_min_y),
        .i_min_z (i_box_min_z),
        .i_max_x (i_box_max_x),
        .i_max_y (i_box_max_y),
        .i_max_z (i_box_max_z),
        .o_beat  (chain[0])
    );

    // One cell per plane; each decodes its own register index.
    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
        assign wr[k].we   = i_cfg_we && (i_cfg_index == CELL_PLANE[k]);
        assign wr[k].data = i_cfg_data;

        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr[k]),
            .i_beat  (chain[k]),
            .o_beat  (chain[k+1])
        );
    end

    assign o_done    = chain[PLANE_COUNT].valid;
    assign o_visible = chain[PLANE_COUNT].vis;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import fbc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BOXES   = 130;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;
    localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sd32767;
    localparam logic signed [NORM_W-1:0] NORM_MIN = -16'sd32768;

    // Register indexes past the last plane; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // Kinds of plane sets used by the random phases.
    typedef enum int {
        SET_AXIS,
        SET_SLANT,
        SET_EXTREME,
        SET_RANDOM,
        SET_OPEN
    } t_plane_set;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mn_x;
        logic signed [COORD_WIDTH-1:0] mn_y;
        logic signed [COORD_WIDTH-1:0] mn_z;
        logic signed [COORD_WIDTH-1:0] mx_x;
        logic signed [COORD_WIDTH-1:0] mx_y;
        logic signed [COORD_WIDTH-1:0] mx_z;
    } t_box_corners;

    // Keeps a copy of the planes and the visibility expected for each box in flight.
    class cull_scoreboard;
        logic [PLANE_W-1:0] planes [PLANE_COUNT];
        bit expected_visible [$];
        int mismatches;
        int unmatched;
        int checked;
        int visible_seen;
        int reports;

        function new();
            foreach (planes[i]) planes[i] = '0;
            mismatches   = 0;
            unmatched    = 0;
            checked      = 0;
            visible_seen = 0;
            reports      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
            if (idx < PLANE_COUNT) begin
                planes[idx] = data;
            end
        endfunction

        // Center and half extents by floor halving, then distance against radius.
        function bit predict_visible(t_box_corners b);
            longint lo [3];
            longint hi [3];
            longint cen [3];
            longint ext [3];
            longint dst;
            longint rad;
            longint n;
            logic signed [NORM_W-1:0] comp;
            bit vis;
            lo[0] = $signed(b.mn_x);
            lo[1] = $signed(b.mn_y);
            lo[2] = $signed(b.mn_z);
            hi[0] = $signed(b.mx_x);
            hi[1] = $signed(b.mx_y);
            hi[2] = $signed(b.mx_z);
            for (int k = 0; k < 3; k++) begin
                cen[k] = (hi[k] + lo[k]) >>> 1;
                ext[k] = (hi[k] - lo[k]) >>> 1;
            end
            vis = 1'b1;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                comp = planes[p][PLANE_W-1 -: NORM_W];
                dst  = comp;
                dst  = dst <<< OFFSET_SHIFT;
                rad  = 0;
                for (int k = 0; k < 3; k++) begin
                    comp = planes[p][NORM_W*k +: NORM_W];
                    n    = comp;
                    dst  = dst + n * cen[k];
                    rad  = rad + ((n < 0) ? -n : n) * ext[k];
                end
                if (!(dst < rad)) begin
                    vis = 1'b0;
                end
            end
            return vis;
        endfunction

        function void note_box(t_box_corners b);
            expected_visible.push_back(predict_visible(b));
        endfunction

        function void check_visible(logic vis);
            bit want;
            if (expected_visible.size() == 0) begin
                unmatched++;
                if (reports < REPORT_LIMIT) begin
                    $display("Result with no box pending: visible=%0b", vis);
                end
                reports++;
            end else begin
                want = expected_visible.pop_front();
                if (vis !== want) begin
                    mismatches++;
                    if (reports < REPORT_LIMIT) begin
                        $display("Mismatch on result %0d: expected visible=%0b, got %0b",
                                 checked, want, vis);
                    end
                    reports++;
                end
                if (vis === 1'b1) begin
                    visible_seen++;
                end
                checked++;
            end
        endfunction

        function int pending();
            return expected_visible.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic signed [COORD_WIDTH-1:0] i_box_min_x;
    logic signed [COORD_WIDTH-1:0] i_box_min_y;
    logic signed [COORD_WIDTH-1:0] i_box_min_z;
    logic signed [COORD_WIDTH-1:0] i_box_max_x;
    logic signed [COORD_WIDTH-1:0] i_box_max_y;
    logic signed [COORD_WIDTH-1:0] i_box_max_z;
    logic                          o_done;
    logic                          o_visible;
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [PLANE_W-1:0]            i_cfg_data;

    cull_scoreboard sb;
    int stall_cycles;
    int plane_settings;

    frustum_box_cull_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_box_min_x (i_box_min_x),
        .i_box_min_y (i_box_min_y),
        .i_box_min_z (i_box_min_z),
        .i_box_max_x (i_box_max_x),
        .i_box_max_y (i_box_max_y),
        .i_box_max_z (i_box_max_z),
        .o_done      (o_done),
        .o_visible   (o_visible),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample the ports at the rising edge: plane writes, accepted boxes and results.
    always @(posedge i_clk) begin : port_monitor
        t_box_corners seen;
        bit           took;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            took = i_start && (o_busy === 1'b0);
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (took) begin
                seen = {i_box_min_x, i_box_min_y, i_box_min_z,
                        i_box_max_x, i_box_max_y, i_box_max_z};
                sb.note_box(seen);
            end
            if (o_done === 1'b1) begin
                sb.check_visible(o_visible);
            end
            stall_cycles <= (took || o_done === 1'b1) ? 0 : stall_cycles + 1;
        end
    end

    // End the run if nothing moves for too long.
    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic t_box_corners mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
        t_box_corners b;
        b.mn_x = x0[COORD_WIDTH-1:0];
        b.mn_y = y0[COORD_WIDTH-1:0];
        b.mn_z = z0[COORD_WIDTH-1:0];
        b.mx_x = x1[COORD_WIDTH-1:0];
        b.mx_y = y1[COORD_WIDTH-1:0];
        b.mx_z = z1[COORD_WIDTH-1:0];
        return b;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        return {d[NORM_W-1:0], nz[NORM_W-1:0], ny[NORM_W-1:0], nx[NORM_W-1:0]};
    endfunction

    // Mostly boxes near the frustum scale, plus full-range, inverted, extreme and tiny ones.
    function automatic t_box_corners make_box();
        int mn [3];
        int mx [3];
        int c;
        int e;
        int kind;
        int t;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            c = int'($urandom_range(0, 20000)) - 10000;
            e = $urandom_range(0, 4000);
            if (kind < 60) begin
                mn[k] = c - e;
                mx[k] = c + e;
            end else if (kind < 75) begin
                mn[k] = $urandom;
                mx[k] = $urandom;
            end else if (kind < 85) begin
                mn[k] = c + e;
                mx[k] = c - e;
            end else if (kind < 92) begin
                mn[k] = extreme_value();
                mx[k] = extreme_value();
            end else begin
                t     = int'($urandom_range(0, 64)) - 32;
                mn[k] = c;
                mx[k] = c + t;
            end
        end
        return mk_box(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one box and hold it until the block takes the beat.
    task automatic send_box(t_box_corners b);
        @(negedge i_clk);
        i_start     = 1'b1;
        i_box_min_x = b.mn_x;
        i_box_min_y = b.mn_y;
        i_box_min_z = b.mn_z;
        i_box_max_x = b.mx_x;
        i_box_max_y = b.mx_y;
        i_box_max_z = b.mx_z;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    // Idle cycles with noise on the box ports, which must be ignored.
    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start     = 1'b0;
            i_box_min_x = $urandom;
            i_box_min_y = $urandom;
            i_box_min_z = $urandom;
            i_box_max_x = $urandom;
            i_box_max_y = $urandom;
            i_box_max_z = $urandom;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        plane_settings++;
    endtask

    // Stop sending and wait for every pending result to come back.
    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Load all six planes for one random phase, plus a write to a spare index.
    task automatic configure_planes(t_plane_set kind);
        int nrm [3];
        int d;
        int sgn;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            sgn = (i % 2 == 0) ? 1 : -1;
            case (kind)
                SET_AXIS: begin
                    nrm = '{0, 0, 0};
                    nrm[i / 2] = sgn * NORM_ONE;
                    d = -int'($urandom_range(0, 8192));
                end
                SET_SLANT: begin
                    for (int k = 0; k < 3; k++) nrm[k] = int'($urandom_range(0, 16384)) - 8192;
                    nrm[i / 2] = sgn * int'($urandom_range(8192, 16383));
                    d = -int'($urandom_range(0, 8192));
                end
                SET_EXTREME: begin
                    for (int k = 0; k < 3; k++) nrm[k] = extreme_value();
                    d = extreme_value();
                end
                SET_OPEN: begin
                    nrm = '{0, 0, 0};
                    d = -int'($urandom_range(1, 32768));
                end
                default: begin
                    nrm = '{$urandom, $urandom, $urandom};
                    d = $urandom;
                end
            endcase
            write_reg(t_plane_idx'(i), pack_plane(nrm[0], nrm[1], nrm[2], d));
        end
        write_reg(($urandom_range(0, 1) == 0) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                  {$urandom, $urandom});
        end_writes();
    endtask

    // Random boxes, in stretches that either run back to back or leave gaps.
    task automatic run_boxes(int count);
        bit burst;
        int gap;
        burst = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) burst = ($urandom_range(0, 99) < 30);
            send_box(make_box());
            gap = burst ? 0 : pick_gap();
            if (gap != 0) idle_cycles(gap);
        end
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_box_min_x    = '0;
        i_box_min_y    = '0;
        i_box_min_z    = '0;
        i_box_max_x    = '0;
        i_box_max_y    = '0;
        i_box_max_z    = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = PLANE_RIGHT;
        i_cfg_data     = '0;
        plane_settings = 0;
        sb             = new();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Planes all zero after reset: every box is culled.
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        idle_cycles(2);
        run_boxes(4);
        settle();

        // One plane on x = 0 facing +x, the rest always pass.
        write_reg(PLANE_RIGHT,  pack_plane(NORM_ONE, 0, 0, 0));
        write_reg(PLANE_LEFT,   pack_plane(0, 0, 0, -1));
        write_reg(PLANE_TOP,    pack_plane(0, 0, 0, -1));
        write_reg(PLANE_BOTTOM, pack_plane(0, 0, 0, -1));
        write_reg(PLANE_NEAR,   pack_plane(0, 0, 0, -1));
        write_reg(PLANE_FAR,    pack_plane(0, 0, 0, -1));
        write_reg(CFG_IDX_SPARE_HI, '1);
        end_writes();

        // Distance equal to radius, odd halving and inverted corners.
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-1, 0, 0, 1, 0, 0));
        send_box(mk_box(0, 0, 0, 4, 0, 0));
        idle_cycles(1);
        send_box(mk_box(-1, 0, 0, 4, 0, 0));
        send_box(mk_box(-3, 0, 0, 0, 0, 0));
        send_box(mk_box(4, 0, 0, -4, 0, 0));
        send_box(mk_box(-2, 0, 0, -10, 0, 0));
        idle_cycles(3);
        // Field extremes and alternating bit patterns.
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(21845, -21846, 21845, -21846, 21845, -21846));
        send_box(mk_box(-21846, 21845, -21846, 21845, -21846, 21845));
        send_box(mk_box(0, -32768, 32767, 1, 32767, -32768));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            configure_planes(t_plane_set'(ph % 5));
            run_boxes(PHASE_BOXES);
        end
        settle();

        $display("Checked %0d box results over %0d plane settings: %0d visible, %0d culled.",
                 sb.checked, plane_settings, sb.visible_seen, sb.checked - sb.visible_seen);
        $display("Mismatches %0d, results with no box %0d, results missing %0d.",
                 sb.mismatches, sb.unmatched, sb.pending());
        if (sb.mismatches == 0 && sb.unmatched == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
